// ===== hdl/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

    // Default arena size in granules
    localparam int HEAP_GRANULES_DEF = 4096;
    // Width of the address and size fields on the ports
    localparam int FIELD_W = 12;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Request payload
    typedef struct packed {
        logic               operation;
        logic [FIELD_W-1:0] req_size;
        logic [FIELD_W-1:0] payload_address;
    } t_req;

    // Response payload
    typedef struct packed {
        logic               alloc_ok;
        logic [FIELD_W-1:0] result_address;
    } t_rsp;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;    // write one entry of the clearing pass
        logic load;     // capture request, start first header read
        logic a_step;   // alloc miss: move to next header and read it
        logic a_split;  // write header of the split remainder
        logic a_hdr;    // write allocated header
        logic f_hdr;    // free: take own header, read following one
        logic f_merge;  // absorb following free block, read the next
        logic f_wb;     // write merged free header
        logic res_ld;   // load response register
        logic res_ok;   // success flag for the response
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_op;      // operation of the pending request
        logic need_zero;  // allocate of size zero
        logic loc_bad;    // free address out of the arena
        logic fit;        // header read is free and large enough
        logic split;      // remainder exceeds one header granule
        logic a_end;      // next header of the walk is the end marker
        logic f_end;      // block after the freed one is the end marker
        logic m_end;      // block after the absorbed one is the end marker
        logic q_start;    // header read is a block start
        logic q_free;     // header read is free
        logic clr_last;   // clearing pass at its last entry
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/ffba_ram.sv =====
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/ffba_dp.sv =====
`default_nettype none

module ffba_dp
    import ffba_pkg::*;
#(
    parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output t_rsp      o_rsp
);

    // Index width, position width and arithmetic width
    localparam int AW = $clog2(HEAP_GRANULES);
    localparam int PW = $clog2(HEAP_GRANULES + 1);
    localparam int XW = ((PW > FIELD_W) ? PW : FIELD_W) + 1;
    localparam int HW = AW + 2;                       // {start, free, size}
    localparam logic [XW-1:0] N_X   = XW'(HEAP_GRANULES);
    localparam logic [XW-1:0] ONE_X = XW'(1);
    localparam logic [AW-1:0] FULL_SIZE = AW'(HEAP_GRANULES - 1);

    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_loc;
    logic [AW-1:0]      r_nx;
    logic [AW-1:0]      r_acc;
    logic [AW-1:0]      r_clr;
    logic [FIELD_W-1:0] r_need;
    logic               r_op;
    t_rsp               r_rsp;

    logic [HW-1:0] q;
    logic          q_start;
    logic          q_free;
    logic [AW-1:0] q_size;

    logic [XW-1:0] q_size_x;
    logic [XW-1:0] need_x;
    logic [XW-1:0] rem_x;
    logic [XW-1:0] in_loc_x;
    logic [XW-1:0] a_next_x;
    logic [XW-1:0] f_next_x;
    logic [XW-1:0] m_next_x;
    logic [XW-1:0] acc_new_x;
    logic [XW-1:0] nh_x;
    logic [XW-1:0] res_addr_x;

    logic          we;
    logic [AW-1:0] waddr;
    logic [HW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;

    assign q_start = q[AW+1];
    assign q_free  = q[AW];
    assign q_size  = q[AW-1:0];

    // Header arithmetic
    assign q_size_x   = XW'(q_size);
    assign need_x     = XW'(r_need);
    assign rem_x      = q_size_x - need_x;
    assign in_loc_x   = XW'(i_req.payload_address) - ONE_X;
    assign a_next_x   = XW'(r_pos) + ONE_X + q_size_x;
    assign f_next_x   = XW'(r_loc) + ONE_X + q_size_x;
    assign m_next_x   = XW'(r_nx) + ONE_X + q_size_x;
    assign acc_new_x  = XW'(r_acc) + ONE_X + q_size_x;
    assign nh_x       = XW'(r_pos) + ONE_X + need_x;
    assign res_addr_x = XW'(r_pos) + ONE_X;

    // Status to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.in_op     = i_req.operation;
        o_sts.need_zero = (i_req.req_size == '0);
        o_sts.loc_bad   = (i_req.payload_address == '0) || (in_loc_x >= N_X);
        o_sts.fit       = q_free && (q_size_x >= need_x);
        o_sts.split     = (rem_x > ONE_X);
        o_sts.a_end     = (a_next_x >= N_X);
        o_sts.f_end     = (f_next_x >= N_X);
        o_sts.m_end     = (m_next_x >= N_X);
        o_sts.q_start   = q_start;
        o_sts.q_free    = q_free;
        o_sts.clr_last  = (r_clr == FULL_SIZE);
    end

    // Read port select
    always_comb begin
        re    = 1'b0;
        raddr = '0;
        if (i_cmd.load) begin
            re    = 1'b1;
            raddr = (i_req.operation == OP_FREE) ? in_loc_x[AW-1:0] : '0;
        end else if (i_cmd.a_step) begin
            re    = 1'b1;
            raddr = a_next_x[AW-1:0];
        end else if (i_cmd.f_hdr) begin
            re    = 1'b1;
            raddr = f_next_x[AW-1:0];
        end else if (i_cmd.f_merge) begin
            re    = 1'b1;
            raddr = m_next_x[AW-1:0];
        end
    end

    // Write port select
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (i_cmd.clear) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = (r_clr == '0) ? {1'b1, 1'b1, FULL_SIZE} : '0;
        end else if (i_cmd.a_split) begin
            we    = 1'b1;
            waddr = nh_x[AW-1:0];
            wdata = {1'b1, 1'b1, AW'(rem_x - ONE_X)};
        end else if (i_cmd.a_hdr) begin
            // size stays whole unless the block was split
            we    = 1'b1;
            waddr = r_pos;
            wdata = {1'b1, 1'b0, (o_sts.split ? AW'(r_need) : q_size)};
        end else if (i_cmd.f_merge) begin
            // absorbed header is no longer a block start
            we    = 1'b1;
            waddr = r_nx;
            wdata = {1'b0, q_free, q_size};
        end else if (i_cmd.f_wb) begin
            we    = 1'b1;
            waddr = r_loc;
            wdata = {1'b1, 1'b1, r_acc};
        end
    end

    ffba_ram #(
        .WIDTH (HW),
        .DEPTH (HEAP_GRANULES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    // Walk registers; clear counter starts at zero on reset, wraps after the pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= (r_clr == FULL_SIZE) ? '0 : r_clr + AW'(1);
        end
        if (i_cmd.load) begin
            r_op   <= i_req.operation;
            r_need <= i_req.req_size;
            r_loc  <= in_loc_x[AW-1:0];
            r_pos  <= '0;
        end
        if (i_cmd.a_step) begin
            r_pos <= a_next_x[AW-1:0];
        end
        if (i_cmd.f_hdr) begin
            r_acc <= q_size;
            r_nx  <= f_next_x[AW-1:0];
        end
        if (i_cmd.f_merge) begin
            r_acc <= acc_new_x[AW-1:0];
            r_nx  <= m_next_x[AW-1:0];
        end
        if (i_cmd.res_ld) begin
            r_rsp.alloc_ok       <= i_cmd.res_ok;
            r_rsp.result_address <= (i_cmd.res_ok && (r_op == OP_ALLOC))
                                    ? res_addr_x[FIELD_W-1:0] : '0;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ===== hdl/ffba_ctrl.sv =====
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_A_CHK,
        S_A_HDR,
        S_F_CHK,
        S_F_MRG,
        S_F_WB,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_ok, n_ok;
    logic   r_rsp_valid, n_rsp_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ok    = r_ok;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_op == OP_ALLOC) begin
                        if (i_sts.need_zero) begin
                            n_ok    = 1'b0;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_A_CHK;
                        end
                    end else if (i_sts.loc_bad) begin
                        n_ok    = 1'b0;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_F_CHK;
                    end
                end
            end
            S_A_CHK: begin
                if (i_sts.fit) begin
                    if (i_sts.split) begin
                        o_cmd.a_split = 1'b1;
                        n_state       = S_A_HDR;
                    end else begin
                        o_cmd.a_hdr = 1'b1;
                        n_ok        = 1'b1;
                        n_state     = S_RESP;
                    end
                end else if (i_sts.a_end) begin
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end else begin
                    o_cmd.a_step = 1'b1;
                end
            end
            S_A_HDR: begin
                o_cmd.a_hdr = 1'b1;
                n_ok        = 1'b1;
                n_state     = S_RESP;
            end
            S_F_CHK: begin
                if (!i_sts.q_start) begin
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end else begin
                    o_cmd.f_hdr = 1'b1;
                    n_state     = i_sts.f_end ? S_F_WB : S_F_MRG;
                end
            end
            S_F_MRG: begin
                if (i_sts.q_free) begin
                    o_cmd.f_merge = 1'b1;
                    if (i_sts.m_end) begin
                        n_state = S_F_WB;
                    end
                end else begin
                    n_state = S_F_WB;
                end
            end
            S_F_WB: begin
                o_cmd.f_wb = 1'b1;
                n_ok       = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                // wait for the response register to be free
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res_ok = r_ok;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Response valid
    always_comb begin
        if (o_cmd.res_ld) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ok        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ok        <= n_ok;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

// ===== hdl/first_fit_block_allocator.sv =====
// Channel   Direction  Handshake                    Payload
// request   in         i_req_valid / o_req_ready    i_req  (t_req)
// response  out        o_rsp_valid / i_rsp_ready    o_rsp  (t_rsp)
//
// Allocate: S_A_CHK checks each header of the first-fit walk, plus S_A_HDR when the block is
// split. Free: S_F_CHK takes its own header, S_F_MRG absorbs following free blocks, S_F_WB
// writes the merged header; a non-start address ends in S_F_CHK, one outside the arena or a
// zero size goes to S_RESP. After reset a clearing pass writes the header RAM; no request
// is taken until it ends. A finished request waits only while the response register is full.
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // Controller
    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath with header RAM
    ffba_dp #(
        .HEAP_GRANULES (HEAP_GRANULES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
